// ----- rtl/grid_ring_free_cell_search_assert.svh -----
// Assertion macros for the free cell search block.
// Used by the controller; relies on clk_i and rst_ni in the including module.
`ifndef GRID_RING_FREE_CELL_SEARCH_ASSERT_SVH
`define GRID_RING_FREE_CELL_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define GRFCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define GRFCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GRFCS_ASSERT_IMP(lbl, ante, cons, msg)
`define GRFCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/grfcs_pkg.sv -----
// Shared types and constants of the free cell search block.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package grfcs_pkg;

  localparam int unsigned MAP_SIDE_DEF  = 256;
  localparam int unsigned ZONE_BITS_DEF = 8;

  // signed ring coordinate width, covers -255 .. 510
  localparam int unsigned CW = 10;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 1'b1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] x;
    logic [7:0] y;
    logic       locked;
    logic [7:0] zone;
    logic [8:0] radius;
    logic       match_zone;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] result_x;
    logic [7:0] result_y;
  } rsp_t;

  typedef struct packed {
    logic clear;     // write zero at sweep address, advance sweep
    logic latch;     // take the input beat, set walker to start cell
    logic write;     // store the latched cell
    logic issue;     // read walker cell, advance walker
    logic res_hit;   // result is the checked cell
    logic res_miss;  // result echoes the request
    logic out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic pend_v;
    logic pend_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/grfcs_ctrl.sv -----
// Controller of the free cell search block: clear sweep, dispatch, scan, output.
// Depends on grfcs_pkg and grid_ring_free_cell_search_assert.svh.
`default_nettype none
`include "grid_ring_free_cell_search_assert.svh"

module grfcs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_req_type_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire grfcs_pkg::sts_t sts_i,
  output grfcs_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_RING  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_d, state_q;
  logic   out_valid_d, out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          state_d = (in_req_type_i == grfcs_pkg::REQ_SEARCH) ? ST_RING : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write    = 1'b1;
        cmd_o.res_miss = 1'b1;
        state_d        = ST_DONE;
      end
      ST_RING: begin
        // check the cell read last cycle while reading the next one
        priority if (sts_i.hit) begin
          cmd_o.res_hit = 1'b1;
          state_d       = ST_DONE;
        end else if (sts_i.pend_v && sts_i.pend_last) begin
          cmd_o.res_miss = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `GRFCS_ASSERT_NXT(a_dispatch, accept, (state_q == ST_WRITE) || (state_q == ST_RING), "accepted beat not dispatched")
  `GRFCS_ASSERT_NXT(a_done_holds, (state_q == ST_DONE) && out_valid_q && out_stall_i, state_q == ST_DONE, "result dropped while output busy")
  `GRFCS_ASSERT_IMP(a_done_entry, $rose(state_q == ST_DONE), $past(cmd_o.res_hit || cmd_o.res_miss), "done without a result")

endmodule

`default_nettype wire

// ----- rtl/grfcs_dp.sv -----
// Datapath of the free cell search block: cell map memory, ring walker,
// cell check stage, result and output registers, limit registers. Uses grfcs_pkg.
`default_nettype none

module grfcs_dp #(
  parameter int unsigned MAP_SIDE  = grfcs_pkg::MAP_SIDE_DEF,
  parameter int unsigned ZONE_BITS = grfcs_pkg::ZONE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire grfcs_pkg::req_t                   in_data_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [grfcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [7:0]                        cfg_wdata_i,
  input  wire grfcs_pkg::cmd_t                   cmd_i,
  output grfcs_pkg::sts_t                        sts_o,
  output grfcs_pkg::rsp_t                        out_data_o
);

  localparam int unsigned CW        = grfcs_pkg::CW;
  localparam int unsigned AW        = $clog2(MAP_SIDE);
  localparam int unsigned MEM_DEPTH = 1 << (2 * AW);
  localparam logic [CW:0] SIDE_C    = (CW + 1)'(MAP_SIDE);

  logic [ZONE_BITS:0] mem [MEM_DEPTH];

  logic [7:0] max_x_q, max_y_q;

  grfcs_pkg::req_t req_q;
  logic [2*AW-1:0] clr_cnt_q;

  // walker
  logic                 first_q;
  logic [CW-1:0]        cx_q, cy_q;
  logic [CW-1:0]        d_q;
  logic [CW-2:0]        t_q;
  grfcs_pkg::dir_e      s_q;

  // check stage
  logic                 pend_v_q;
  logic                 pend_inb_q, pend_last_q;
  logic [CW-1:0]        pend_x_q, pend_y_q;
  logic [ZONE_BITS:0]   rd_q;

  grfcs_pkg::rsp_t      res_q, out_q;

  logic [ZONE_BITS-1:0] want_zone;
  logic                 map_ok, ring_ok, cell_inb;
  logic                 t_end, ring_end, walk_last;
  logic [CW-1:0]        d_plus2;
  logic [CW-1:0]        dx, dy;
  logic                 req_in_map;
  logic                 mem_we;
  logic [2*AW-1:0]      mem_waddr, mem_raddr;
  logic [ZONE_BITS:0]   mem_wdata;

  assign want_zone = ZONE_BITS'(req_q.zone);

  // walker cell position checks, MSB of a coordinate is its sign
  assign map_ok = !cx_q[CW-1] && !cy_q[CW-1] && ({1'b0, cx_q} < SIDE_C)
                  && ({1'b0, cy_q} < SIDE_C);
  assign ring_ok = (cx_q != '0) && !cx_q[CW-1] && (cx_q <= CW'(max_x_q))
                   && !cy_q[CW-1] && (cy_q > CW'(1)) && (cy_q <= CW'(max_y_q));
  assign cell_inb = first_q ? map_ok : (map_ok && ring_ok);

  assign d_plus2   = d_q + CW'(2);
  assign t_end     = (CW'(t_q) + CW'(1)) == d_q;
  assign ring_end  = (s_q == grfcs_pkg::DIR_UP) && t_end;
  assign walk_last = first_q ? (req_q.radius <= 9'd2)
                             : (ring_end && (d_plus2 >= {1'b0, req_q.radius}));

  always_comb begin
    dx = '0;
    dy = '0;
    unique case (s_q)
      grfcs_pkg::DIR_RIGHT: dx = CW'(1);
      grfcs_pkg::DIR_DOWN:  dy = CW'(1);
      grfcs_pkg::DIR_LEFT:  dx = '1;
      grfcs_pkg::DIR_UP:    dy = '1;
      default:              dx = '0;
    endcase
  end

  assign req_in_map = ({3'b0, req_q.x} < SIDE_C) && ({3'b0, req_q.y} < SIDE_C);

  assign mem_we    = cmd_i.clear || (cmd_i.write && req_in_map);
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : {AW'(req_q.y), AW'(req_q.x)};
  assign mem_wdata = cmd_i.clear ? '0 : {req_q.locked, want_zone};
  assign mem_raddr = {cy_q[AW-1:0], cx_q[AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q   <= 8'd255;
      max_y_q   <= 8'd255;
      clr_cnt_q <= '0;
      pend_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          grfcs_pkg::REG_MAX_X: max_x_q <= cfg_wdata_i;
          grfcs_pkg::REG_MAX_Y: max_y_q <= cfg_wdata_i;
          default:              max_x_q <= max_x_q;
        endcase
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      pend_v_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= in_data_i;
      first_q <= 1'b1;
      cx_q    <= CW'(in_data_i.x);
      cy_q    <= CW'(in_data_i.y);
      d_q     <= CW'(2);
      t_q     <= '0;
      s_q     <= grfcs_pkg::DIR_RIGHT;
    end else if (cmd_i.issue) begin
      if (first_q) begin
        // first ring corner sits one up and left of the start cell
        first_q <= 1'b0;
        cx_q    <= cx_q - CW'(1);
        cy_q    <= cy_q - CW'(1);
        d_q     <= CW'(2);
        t_q     <= '0;
        s_q     <= grfcs_pkg::DIR_RIGHT;
      end else if (ring_end) begin
        // last cell of the up leg: pass the corner and step out one ring
        cx_q <= cx_q - CW'(1);
        cy_q <= cy_q - CW'(2);
        d_q  <= d_plus2;
        t_q  <= '0;
        s_q  <= grfcs_pkg::DIR_RIGHT;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q + dy;
        if (t_end) begin
          t_q <= '0;
          s_q <= grfcs_pkg::dir_e'(s_q + 2'd1);
        end else begin
          t_q <= t_q + 1'b1;
        end
      end
    end
    if (cmd_i.issue) begin
      pend_x_q    <= cx_q;
      pend_y_q    <= cy_q;
      pend_inb_q  <= cell_inb;
      pend_last_q <= walk_last;
    end
    if (cmd_i.res_hit) begin
      res_q.found    <= 1'b1;
      res_q.result_x <= pend_x_q[7:0];
      res_q.result_y <= pend_y_q[7:0];
    end else if (cmd_i.res_miss) begin
      res_q.found    <= 1'b0;
      res_q.result_x <= req_q.x;
      res_q.result_y <= req_q.y;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.clr_done  = &clr_cnt_q;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.pend_last = pend_last_q;
  assign sts_o.hit       = pend_v_q && pend_inb_q && !rd_q[ZONE_BITS]
                           && (!req_q.match_zone || (rd_q[ZONE_BITS-1:0] == want_zone));

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/grid_ring_free_cell_search.sv -----
// Write beat: latched, then stored with its echo as result. Search beat: latched, then
//   reads the start cell, then 4*d cells per ring for even d from 2 below radius.
// Throughput: one beat at a time; the scan reads one map cell per cycle through
//   the single read port of the cell map. A result may wait while the next beat runs.
// Reset: limits go to 255; the cell map is swept to zero, one entry per cycle,
//   all 2^(2*ceil(log2(MAP_SIDE))) entries (65536 by default), before the first beat.
`default_nettype none

module grid_ring_free_cell_search #(
  parameter int unsigned MAP_SIDE  = grfcs_pkg::MAP_SIDE_DEF,
  parameter int unsigned ZONE_BITS = grfcs_pkg::ZONE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire grfcs_pkg::req_t                 in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output grfcs_pkg::rsp_t                      out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [grfcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                      cfg_wdata_i
);

  grfcs_pkg::cmd_t cmd;
  grfcs_pkg::sts_t sts;

  grfcs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  grfcs_dp #(
    .MAP_SIDE  (MAP_SIDE),
    .ZONE_BITS (ZONE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
